// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules of the grid pattern matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

// ===== hw/rtl/gpm_pkg.sv =====
// Package with constants, command codes, types and modular helpers of the matcher.
package gpm_pkg;

  localparam int MAX_TEXT    = 64;
  localparam int MAX_PATTERN = 16;

  localparam int HASH_W = 30;
  localparam logic [HASH_W-1:0] HMOD     = HASH_W'(1000000007);
  localparam logic [HASH_W-1:0] ROW_BASE = HASH_W'(911382323);
  localparam logic [HASH_W-1:0] COL_BASE = HASH_W'(972663749);

  localparam int SYM_W     = 8;
  localparam int CMD_W     = 2;
  localparam int OUT_W     = 6;
  localparam int TS_W      = 7;
  localparam int PS_W      = 5;
  localparam int CFG_DW    = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_SIZE  = 1'd1;

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PAT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT  = 2'd2;

  localparam int TP_W       = $clog2(MAX_TEXT + 1);
  localparam int M_W        = $clog2(MAX_PATTERN + 1);
  localparam int PI_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PAT_DEPTH  = MAX_PATTERN * MAX_PATTERN;
  localparam int PA_W       = (PAT_DEPTH > 1) ? $clog2(PAT_DEPTH) : 1;
  localparam int PP_W       = $clog2(PAT_DEPTH + 1);
  localparam int TXT_DEPTH  = MAX_TEXT * MAX_TEXT;
  localparam int TA_W       = $clog2(TXT_DEPTH);
  localparam int RING       = MAX_PATTERN + 1;
  localparam int RING_DEPTH = RING * MAX_TEXT;
  localparam int RA_W       = $clog2(RING_DEPTH);
  localparam int SL_W       = $clog2(RING);
  localparam int MC_W       = $clog2(HASH_W);

  localparam int TERM_W = 3;

  localparam logic [1:0] TO_HOLD = 2'd0;
  localparam logic [1:0] TO_CLR  = 2'd1;
  localparam logic [1:0] TO_INC  = 2'd2;
  localparam logic [1:0] TO_WIN  = 2'd3;

  localparam logic [2:0] MS_F_CELL = 3'd0;
  localparam logic [2:0] MS_F_HASH = 3'd1;
  localparam logic [2:0] MS_F_RPOW = 3'd2;
  localparam logic [2:0] MS_F_CPOW = 3'd3;
  localparam logic [2:0] MS_T_K1   = 3'd4;
  localparam logic [2:0] MS_T_K2   = 3'd5;

  localparam logic [2:0] ACC_NONE = 3'd0;
  localparam logic [2:0] ACC_SYM  = 3'd1;
  localparam logic [2:0] ACC_ZERO = 3'd2;
  localparam logic [2:0] ACC_CELL = 3'd3;
  localparam logic [2:0] ACC_TERM = 3'd4;

  typedef struct packed {
    logic       job_start;
    logic       pat_we;
    logic       text_we;
    logic       ring_we;
    logic       fin_init;
    logic       row_init;
    logic       cell_adv;
    logic       row_adv;
    logic       set_ready;
    logic       hash_upd;
    logic       rpow_upd;
    logic       cpow_upd;
    logic       cmp_init;
    logic       cmp_adv;
    logic       out_load;
    logic       pos_adv;
    logic       mul_start;
    logic [2:0] mul_sel;
    logic [2:0] acc_op;
    logic [1:0] term_op;
  } dp_cmd_t;

  typedef struct packed {
    logic pat_take;
    logic pat_last;
    logic text_take;
    logic term_cond;
    logic term_dbl;
    logic term_is2;
    logic term_is5;
    logic window;
    logic hash_hit;
    logic f_col_last;
    logic f_row_last;
    logic cmp_eq;
    logic cmp_last;
    logic mul_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic [HASH_W-1:0] red3(input logic [HASH_W+1:0] x);
    logic [HASH_W+1:0] p1;
    logic [HASH_W+1:0] p2;
    logic [HASH_W+1:0] s;
    p1 = {2'b00, HMOD};
    p2 = {1'b0, HMOD, 1'b0};
    s  = x;
    if (s >= p2) begin
      s = s - p2;
    end else if (s >= p1) begin
      s = s - p1;
    end
    return s[HASH_W-1:0];
  endfunction

  function automatic logic [HASH_W-1:0] addmod(input logic [HASH_W-1:0] a,
                                               input logic [HASH_W-1:0] b);
    logic [HASH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, HMOD}) begin
      s = s - {1'b0, HMOD};
    end
    return s[HASH_W-1:0];
  endfunction

  function automatic logic [HASH_W-1:0] submod(input logic [HASH_W-1:0] a,
                                               input logic [HASH_W-1:0] b);
    logic [HASH_W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + {1'b0, HMOD} - {1'b0, b};
    end
    return s[HASH_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/gpm_chan_if.sv =====
// Valid/ready channel interfaces for requests and match results.
interface gpm_in_if import gpm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [SYM_W-1:0] symbol;
  modport source (output valid, cmd, symbol, input ready);
  modport sink (input valid, cmd, symbol, output ready);
endinterface

interface gpm_out_if import gpm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] match_row;
  logic [OUT_W-1:0] match_col;
  modport source (output valid, match_row, match_col, input ready);
  modport sink (input valid, match_row, match_col, output ready);
endinterface

// ===== hw/rtl/grid_pattern_match_rolling_hash.sv =====
// Top level of the 2D rolling-hash grid pattern matcher.
// A start or pattern request is taken while idle; the last pattern symbol starts the pattern hashing.
// A text request runs up to 8 modular multiplications on one bit-serial multiplier, plus
// m*m store reads for the symbol compare when the window hash hits.
// One request is in work at a time; a found match waits in the output register.
// Synchronous active-low reset restores text_size 64, pattern_size 2 and clears the job.
module grid_pattern_match_rolling_hash import gpm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  gpm_in_if.sink               in_ch,
  gpm_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata
);
  dp_cmd_t  cmd;
  dp_stat_t st;

  gpm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_cmd  (in_ch.cmd),
    .in_ready(in_ch.ready),
    .st      (st),
    .cmd     (cmd)
  );

  gpm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_symbol(in_ch.symbol),
    .out_ready(out_ch.ready),
    .out_valid(out_ch.valid),
    .out_row  (out_ch.match_row),
    .out_col  (out_ch.match_col),
    .cmd      (cmd),
    .st       (st)
  );
endmodule

// ===== hw/rtl/gpm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/gpm_mulmod.sv =====
// Bit-serial modular multiplier, one bit of the multiplier per cycle.
module gpm_mulmod import gpm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HASH_W-1:0] a,
  input  logic [HASH_W-1:0] b,
  output logic              done,
  output logic [HASH_W-1:0] prod
);
`include "assert_macros.svh"

  logic              busy_r;
  logic              done_r;
  logic [MC_W-1:0]   cnt_r;
  logic [HASH_W-1:0] a_r;
  logic [HASH_W-1:0] b_r;
  logic [HASH_W-1:0] acc_r;
  logic [HASH_W+1:0] step_sum;

  assign step_sum = {1'b0, acc_r, 1'b0} + (b_r[HASH_W-1] ? {2'b00, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
      cnt_r <= MC_W'(HASH_W - 1);
    end else if (busy_r) begin
      acc_r <= red3(step_sum);
      b_r   <= {b_r[HASH_W-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

  `ASSERT_IMPL(a_no_restart, clk, rst_n, start, !busy_r)
  `ASSERT_NEXT(a_done_after_last, clk, rst_n, busy_r && cnt_r == '0 && !start, done_r)
endmodule

// ===== hw/rtl/gpm_ctrl.sv =====
// Controller state machine that sequences hashing, prefix updates and compares.
module gpm_ctrl import gpm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  input  dp_stat_t         st,
  output dp_cmd_t          cmd
);
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_F_ROW   = 5'd1;
  localparam logic [4:0] S_F_CELL  = 5'd2;
  localparam logic [4:0] S_F_CELLW = 5'd3;
  localparam logic [4:0] S_F_H     = 5'd4;
  localparam logic [4:0] S_F_HW    = 5'd5;
  localparam logic [4:0] S_F_R     = 5'd6;
  localparam logic [4:0] S_F_RW    = 5'd7;
  localparam logic [4:0] S_F_C     = 5'd8;
  localparam logic [4:0] S_F_CW    = 5'd9;
  localparam logic [4:0] S_T_SEL   = 5'd10;
  localparam logic [4:0] S_T_RD    = 5'd11;
  localparam logic [4:0] S_T_M1    = 5'd12;
  localparam logic [4:0] S_T_M2    = 5'd13;
  localparam logic [4:0] S_T_WR    = 5'd14;
  localparam logic [4:0] S_T_HIT   = 5'd15;
  localparam logic [4:0] S_C_RD    = 5'd16;
  localparam logic [4:0] S_C_CHK   = 5'd17;
  localparam logic [4:0] S_T_OUT   = 5'd18;
  localparam logic [4:0] S_T_ADV   = 5'd19;

  logic [4:0] state_r;
  logic [4:0] state_nxt;
  logic [4:0] after_term;
  logic [1:0] after_term_op;

  always_comb begin
    if (st.term_is2) begin
      after_term    = S_T_WR;
      after_term_op = TO_HOLD;
    end else if (st.term_is5) begin
      after_term    = S_T_HIT;
      after_term_op = TO_HOLD;
    end else begin
      after_term    = S_T_SEL;
      after_term_op = TO_INC;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_cmd)
            CMD_START: begin
              cmd.job_start = 1'b1;
            end
            CMD_PAT: begin
              if (st.pat_take) begin
                cmd.pat_we = 1'b1;
                if (st.pat_last) begin
                  cmd.fin_init = 1'b1;
                  state_nxt    = S_F_ROW;
                end
              end
            end
            CMD_TEXT: begin
              if (st.text_take) begin
                cmd.text_we = 1'b1;
                cmd.acc_op  = ACC_SYM;
                cmd.term_op = TO_CLR;
                state_nxt   = S_T_SEL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_F_ROW: begin
        cmd.acc_op   = ACC_ZERO;
        cmd.row_init = 1'b1;
        state_nxt    = S_F_CELL;
      end
      S_F_CELL: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_F_CELL;
        state_nxt     = S_F_CELLW;
      end
      S_F_CELLW: begin
        if (st.mul_done) begin
          cmd.acc_op   = ACC_CELL;
          cmd.cell_adv = 1'b1;
          state_nxt    = st.f_col_last ? S_F_H : S_F_CELL;
        end
      end
      S_F_H: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_F_HASH;
        state_nxt     = S_F_HW;
      end
      S_F_HW: begin
        if (st.mul_done) begin
          cmd.hash_upd = 1'b1;
          state_nxt    = S_F_R;
        end
      end
      S_F_R: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_F_RPOW;
        state_nxt     = S_F_RW;
      end
      S_F_RW: begin
        if (st.mul_done) begin
          cmd.rpow_upd = 1'b1;
          state_nxt    = S_F_C;
        end
      end
      S_F_C: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_F_CPOW;
        state_nxt     = S_F_CW;
      end
      S_F_CW: begin
        if (st.mul_done) begin
          cmd.cpow_upd = 1'b1;
          cmd.row_adv  = 1'b1;
          if (st.f_row_last) begin
            cmd.set_ready = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_F_ROW;
          end
        end
      end
      S_T_SEL: begin
        if (st.term_cond) begin
          state_nxt = S_T_RD;
        end else begin
          cmd.term_op = after_term_op;
          state_nxt   = after_term;
        end
      end
      S_T_RD: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_T_K1;
        state_nxt     = S_T_M1;
      end
      S_T_M1: begin
        if (st.mul_done) begin
          if (st.term_dbl) begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MS_T_K2;
            state_nxt     = S_T_M2;
          end else begin
            cmd.acc_op  = ACC_TERM;
            cmd.term_op = after_term_op;
            state_nxt   = after_term;
          end
        end
      end
      S_T_M2: begin
        if (st.mul_done) begin
          cmd.acc_op  = ACC_TERM;
          cmd.term_op = after_term_op;
          state_nxt   = after_term;
        end
      end
      S_T_WR: begin
        cmd.ring_we = 1'b1;
        if (st.window) begin
          cmd.term_op = TO_WIN;
          state_nxt   = S_T_SEL;
        end else begin
          state_nxt = S_T_ADV;
        end
      end
      S_T_HIT: begin
        if (st.hash_hit) begin
          cmd.cmp_init = 1'b1;
          state_nxt    = S_C_RD;
        end else begin
          state_nxt = S_T_ADV;
        end
      end
      S_C_RD: begin
        state_nxt = S_C_CHK;
      end
      S_C_CHK: begin
        if (!st.cmp_eq) begin
          state_nxt = S_T_ADV;
        end else if (st.cmp_last) begin
          state_nxt = S_T_OUT;
        end else begin
          cmd.cmp_adv = 1'b1;
          state_nxt   = S_C_RD;
        end
      end
      S_T_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_T_ADV;
        end
      end
      S_T_ADV: begin
        cmd.pos_adv = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// ===== hw/rtl/gpm_dp.sv =====
// Datapath with grid stores, prefix hash ring, modular multiplier and result register.
module gpm_dp import gpm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata,
  input  logic [SYM_W-1:0]     in_symbol,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [OUT_W-1:0]     out_row,
  output logic [OUT_W-1:0]     out_col,
  input  dp_cmd_t              cmd,
  output dp_stat_t             st
);
`include "assert_macros.svh"

  localparam logic [TERM_W-1:0] T_UP    = 3'd0;
  localparam logic [TERM_W-1:0] T_LEFT  = 3'd1;
  localparam logic [TERM_W-1:0] T_DIAG  = 3'd2;
  localparam logic [TERM_W-1:0] T_WTOP  = 3'd3;
  localparam logic [TERM_W-1:0] T_WLEFT = 3'd4;
  localparam logic [TERM_W-1:0] T_WDIAG = 3'd5;

  logic [TS_W-1:0]   text_size_r;
  logic [PS_W-1:0]   pattern_size_r;
  logic [PP_W-1:0]   pat_pos_r;
  logic [TP_W-1:0]   row_r;
  logic [TP_W-1:0]   col_r;
  logic [SL_W-1:0]   slot_r;
  logic              pat_ready_r;
  logic [HASH_W-1:0] pat_hash_r;
  logic [HASH_W-1:0] rpow_r;
  logic [HASH_W-1:0] cpow_r;
  logic [TERM_W-1:0] term_r;
  logic              out_valid_r;
  logic [HASH_W-1:0] acc_r;
  logic [PA_W-1:0]   pa_r;
  logic [PI_W-1:0]   fa_r;
  logic [PI_W-1:0]   fb_r;
  logic [PI_W-1:0]   ca_r;
  logic [PI_W-1:0]   cb_r;
  logic [OUT_W-1:0]  out_row_r;
  logic [OUT_W-1:0]  out_col_r;

  logic [M_W-1:0]    m_eff;
  logic [TP_W-1:0]   n_eff;
  int                mi;
  int                ri;
  int                ci;
  int                xi;
  int                yi;
  int                up_slot;
  int                top_slot;
  logic [PP_W-1:0]   mm;
  logic              job_clr;

  int                t_slot;
  int                t_col;
  logic              t_cond;
  logic              t_dbl;
  logic              t_sub;
  logic [HASH_W-1:0] t_k1;
  logic [HASH_W-1:0] t_k2;

  logic [HASH_W-1:0] mul_a;
  logic [HASH_W-1:0] mul_b;
  logic              mul_done;
  logic [HASH_W-1:0] prod;

  logic [SYM_W-1:0]  pat_rdata;
  logic [SYM_W-1:0]  text_rdata;
  logic [HASH_W-1:0] ring_rdata;

  always_comb begin
    if (pattern_size_r == '0) begin
      m_eff = M_W'(1);
    end else if (int'(pattern_size_r) > MAX_PATTERN) begin
      m_eff = M_W'(MAX_PATTERN);
    end else begin
      m_eff = M_W'(pattern_size_r);
    end
    if (text_size_r == '0) begin
      n_eff = TP_W'(1);
    end else if (int'(text_size_r) > MAX_TEXT) begin
      n_eff = TP_W'(MAX_TEXT);
    end else begin
      n_eff = TP_W'(text_size_r);
    end
  end

  assign mi       = int'(m_eff);
  assign ri       = int'(row_r);
  assign ci       = int'(col_r);
  assign xi       = ri + 1 - mi;
  assign yi       = ci + 1 - mi;
  assign mm       = PP_W'(mi * mi);
  assign up_slot  = (slot_r == '0) ? (RING - 1) : (int'(slot_r) - 1);
  assign top_slot = (int'(slot_r) >= mi) ? (int'(slot_r) - mi) : (int'(slot_r) + RING - mi);
  assign job_clr  = cmd.job_start || cfg_we;

  always_comb begin
    t_slot = int'(slot_r);
    t_col  = ci;
    t_cond = 1'b0;
    t_dbl  = 1'b0;
    t_sub  = 1'b0;
    t_k1   = ROW_BASE;
    t_k2   = COL_BASE;
    case (term_r)
      T_UP: begin
        t_slot = up_slot;
        t_cond = (ri > 0);
      end
      T_LEFT: begin
        t_col  = ci - 1;
        t_cond = (ci > 0);
        t_k1   = COL_BASE;
      end
      T_DIAG: begin
        t_slot = up_slot;
        t_col  = ci - 1;
        t_cond = (ri > 0) && (ci > 0);
        t_dbl  = 1'b1;
        t_sub  = 1'b1;
      end
      T_WTOP: begin
        t_slot = top_slot;
        t_cond = (xi > 0);
        t_sub  = 1'b1;
        t_k1   = rpow_r;
      end
      T_WLEFT: begin
        t_col  = yi - 1;
        t_cond = (yi > 0);
        t_sub  = 1'b1;
        t_k1   = cpow_r;
      end
      T_WDIAG: begin
        t_slot = top_slot;
        t_col  = yi - 1;
        t_cond = (xi > 0) && (yi > 0);
        t_dbl  = 1'b1;
        t_k1   = rpow_r;
        t_k2   = cpow_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (cmd.mul_sel)
      MS_F_CELL: begin
        mul_a = acc_r;
        mul_b = COL_BASE;
      end
      MS_F_HASH: begin
        mul_a = pat_hash_r;
        mul_b = ROW_BASE;
      end
      MS_F_RPOW: begin
        mul_a = rpow_r;
        mul_b = ROW_BASE;
      end
      MS_F_CPOW: begin
        mul_a = cpow_r;
        mul_b = COL_BASE;
      end
      MS_T_K1: begin
        mul_a = ring_rdata;
        mul_b = t_k1;
      end
      MS_T_K2: begin
        mul_a = prod;
        mul_b = t_k2;
      end
      default: begin
        mul_a = acc_r;
        mul_b = COL_BASE;
      end
    endcase
  end

  gpm_mulmod u_mulmod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (prod)
  );

  gpm_ram #(.WIDTH(SYM_W), .DEPTH(PAT_DEPTH)) u_pat_ram (
    .clk  (clk),
    .we   (cmd.pat_we),
    .waddr(PA_W'(pat_pos_r)),
    .wdata(in_symbol),
    .raddr(pa_r),
    .rdata(pat_rdata)
  );

  gpm_ram #(.WIDTH(SYM_W), .DEPTH(TXT_DEPTH)) u_text_ram (
    .clk  (clk),
    .we   (cmd.text_we),
    .waddr(TA_W'(ri * MAX_TEXT + ci)),
    .wdata(in_symbol),
    .raddr(TA_W'((xi + int'(ca_r)) * MAX_TEXT + yi + int'(cb_r))),
    .rdata(text_rdata)
  );

  gpm_ram #(.WIDTH(HASH_W), .DEPTH(RING_DEPTH)) u_ring_ram (
    .clk  (clk),
    .we   (cmd.ring_we),
    .waddr(RA_W'(int'(slot_r) * MAX_TEXT + ci)),
    .wdata(acc_r),
    .raddr(RA_W'(t_slot * MAX_TEXT + t_col)),
    .rdata(ring_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_size_r    <= TS_W'(64);
      pattern_size_r <= PS_W'(2);
      pat_pos_r      <= '0;
      row_r          <= '0;
      col_r          <= '0;
      slot_r         <= '0;
      pat_ready_r    <= 1'b0;
      pat_hash_r     <= '0;
      rpow_r         <= HASH_W'(1);
      cpow_r         <= HASH_W'(1);
      term_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TEXT_SIZE: text_size_r <= cfg_wdata[TS_W-1:0];
          CFG_PAT_SIZE:  pattern_size_r <= cfg_wdata[PS_W-1:0];
          default: begin
          end
        endcase
      end
      if (job_clr) begin
        pat_pos_r   <= '0;
        row_r       <= '0;
        col_r       <= '0;
        slot_r      <= '0;
        pat_ready_r <= 1'b0;
        pat_hash_r  <= '0;
        rpow_r      <= HASH_W'(1);
        cpow_r      <= HASH_W'(1);
      end else begin
        if (cmd.pat_we) begin
          pat_pos_r <= pat_pos_r + 1'b1;
        end
        if (cmd.fin_init) begin
          pat_hash_r <= '0;
          rpow_r     <= HASH_W'(1);
          cpow_r     <= HASH_W'(1);
        end
        if (cmd.hash_upd) begin
          pat_hash_r <= addmod(prod, acc_r);
        end
        if (cmd.rpow_upd) begin
          rpow_r <= prod;
        end
        if (cmd.cpow_upd) begin
          cpow_r <= prod;
        end
        if (cmd.set_ready) begin
          pat_ready_r <= 1'b1;
        end
        if (cmd.pos_adv) begin
          if (ci + 1 >= int'(n_eff)) begin
            col_r  <= '0;
            row_r  <= row_r + 1'b1;
            slot_r <= (int'(slot_r) == RING - 1) ? '0 : slot_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
      end
      case (cmd.term_op)
        TO_CLR:  term_r <= T_UP;
        TO_INC:  term_r <= term_r + 1'b1;
        TO_WIN:  term_r <= T_WTOP;
        default: begin
        end
      endcase
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      ACC_SYM:  acc_r <= HASH_W'(in_symbol);
      ACC_ZERO: acc_r <= '0;
      ACC_CELL: acc_r <= addmod(prod, HASH_W'(pat_rdata));
      ACC_TERM: acc_r <= t_sub ? submod(acc_r, prod) : addmod(acc_r, prod);
      default: begin
      end
    endcase
    if (cmd.fin_init || cmd.cmp_init) begin
      pa_r <= '0;
    end else if (cmd.cell_adv || cmd.cmp_adv) begin
      pa_r <= pa_r + 1'b1;
    end
    if (cmd.fin_init) begin
      fa_r <= '0;
    end else if (cmd.row_adv) begin
      fa_r <= fa_r + 1'b1;
    end
    if (cmd.row_init) begin
      fb_r <= '0;
    end else if (cmd.cell_adv) begin
      fb_r <= fb_r + 1'b1;
    end
    if (cmd.cmp_init) begin
      ca_r <= '0;
      cb_r <= '0;
    end else if (cmd.cmp_adv) begin
      if (int'(cb_r) == mi - 1) begin
        cb_r <= '0;
        ca_r <= ca_r + 1'b1;
      end else begin
        cb_r <= cb_r + 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_row_r <= OUT_W'(xi);
      out_col_r <= OUT_W'(yi);
    end
  end

  always_comb begin
    st.pat_take   = !pat_ready_r && (pat_pos_r < mm);
    st.pat_last   = (int'(pat_pos_r) + 1 == int'(mm));
    st.text_take  = pat_ready_r && (row_r < n_eff) && (col_r < n_eff);
    st.term_cond  = t_cond;
    st.term_dbl   = t_dbl;
    st.term_is2   = (term_r == T_DIAG);
    st.term_is5   = (term_r == T_WDIAG);
    st.window     = (ri + 1 >= mi) && (ci + 1 >= mi);
    st.hash_hit   = (acc_r == pat_hash_r);
    st.f_col_last = (int'(fb_r) == mi - 1);
    st.f_row_last = (int'(fa_r) == mi - 1);
    st.cmp_eq     = (text_rdata == pat_rdata);
    st.cmp_last   = (int'(ca_r) == mi - 1) && (int'(cb_r) == mi - 1);
    st.mul_done   = mul_done;
    st.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;

  `ASSERT_IMPL(a_out_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_r || out_ready)
  `ASSERT_IMPL(a_ready_full_pattern, clk, rst_n, pat_ready_r, pat_pos_r == mm)
endmodule
